// ===== rtl/ccb_pkg.sv =====
`timescale 1ns / 1ps

package ccb_pkg;

  localparam int unsigned SIZE_W  = 13;
  localparam int unsigned PIXEL_W = 32;
  localparam int unsigned ADDR_W  = 24;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned IDX_W   = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_DEST_X       = 3'd0,
    REG_DEST_Y       = 3'd1,
    REG_SRC_WIDTH    = 3'd2,
    REG_SRC_HEIGHT   = 3'd3,
    REG_IMAGE_WIDTH  = 3'd4,
    REG_IMAGE_HEIGHT = 3'd5,
    REG_KEY_ENABLE   = 3'd6,
    REG_KEY_COLOR    = 3'd7
  } cfg_idx_e;

  // sizes are already clamped to the legal range
  typedef struct packed {
    logic signed [SIZE_W-1:0] dest_x;
    logic signed [SIZE_W-1:0] dest_y;
    logic [SIZE_W-1:0]        src_width;
    logic [SIZE_W-1:0]        src_height;
    logic [SIZE_W-1:0]        image_width;
    logic [SIZE_W-1:0]        image_height;
    logic                     key_enable;
    logic [PIXEL_W-1:0]       key_color;
  } cfg_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] src_pixel;
  } src_word_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  pixel_address;
    logic [PIXEL_W-1:0] pixel_color;
  } wr_word_t;

endpackage

// ===== rtl/ccb_stream_if.sv =====
`timescale 1ns / 1ps

interface ccb_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/ccb_cfg_regs.sv =====
`timescale 1ns / 1ps

module ccb_cfg_regs #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ccb_pkg::IDX_W-1:0]         cfg_idx_i,
  input  logic [ccb_pkg::CFG_W-1:0]         cfg_data_i,
  output ccb_pkg::cfg_t                     cfg_o
);
  import ccb_pkg::*;

  localparam logic [31:0] MaxW = 32'(MAX_WIDTH);
  localparam logic [31:0] MaxH = 32'(MAX_HEIGHT);

  logic [SIZE_W-1:0]  dest_x_q, dest_y_q, src_w_q, src_h_q, img_w_q, img_h_q;
  logic               key_en_q;
  logic [PIXEL_W-1:0] key_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_x_q    <= '0;
      dest_y_q    <= '0;
      src_w_q     <= SIZE_W'(1);
      src_h_q     <= SIZE_W'(1);
      img_w_q     <= SIZE_W'(1);
      img_h_q     <= SIZE_W'(1);
      key_en_q    <= 1'b0;
      key_color_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_DEST_X:       dest_x_q    <= cfg_data_i[SIZE_W-1:0];
        REG_DEST_Y:       dest_y_q    <= cfg_data_i[SIZE_W-1:0];
        REG_SRC_WIDTH:    src_w_q     <= cfg_data_i[SIZE_W-1:0];
        REG_SRC_HEIGHT:   src_h_q     <= cfg_data_i[SIZE_W-1:0];
        REG_IMAGE_WIDTH:  img_w_q     <= cfg_data_i[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: img_h_q     <= cfg_data_i[SIZE_W-1:0];
        REG_KEY_ENABLE:   key_en_q    <= cfg_data_i[0];
        REG_KEY_COLOR:    key_color_q <= cfg_data_i[PIXEL_W-1:0];
        default: ;
      endcase
    end
  end

  // source sizes: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    cfg_o.dest_x     = $signed(dest_x_q);
    cfg_o.dest_y     = $signed(dest_y_q);
    cfg_o.key_enable = key_en_q;
    cfg_o.key_color  = key_color_q;

    if (src_w_q == '0)                 cfg_o.src_width = SIZE_W'(1);
    else if (32'(src_w_q) > MaxW)      cfg_o.src_width = SIZE_W'(MAX_WIDTH);
    else                               cfg_o.src_width = src_w_q;

    if (src_h_q == '0)                 cfg_o.src_height = SIZE_W'(1);
    else if (32'(src_h_q) > MaxH)      cfg_o.src_height = SIZE_W'(MAX_HEIGHT);
    else                               cfg_o.src_height = src_h_q;

    // image sizes: zero stays zero and drops every pixel
    if (32'(img_w_q) > MaxW)           cfg_o.image_width = SIZE_W'(MAX_WIDTH);
    else                               cfg_o.image_width = img_w_q;

    if (32'(img_h_q) > MaxH)           cfg_o.image_height = SIZE_W'(MAX_HEIGHT);
    else                               cfg_o.image_height = img_h_q;
  end

endmodule

// ===== rtl/ccb_walker.sv =====
`timescale 1ns / 1ps

module ccb_walker #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned COL_W = $clog2(MAX_WIDTH),
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ccb_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [ccb_pkg::PIXEL_W-1:0]  in_pixel_i,
  output logic                         s1_valid_o,
  input  logic                         s1_take_i,
  output logic [ccb_pkg::PIXEL_W-1:0]  s1_pixel_o,
  output logic [COL_W-1:0]             s1_col_o,
  output logic [ROW_W-1:0]             s1_row_o
);
  import ccb_pkg::*;

  localparam int unsigned CCMP_W = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;
  localparam int unsigned RCMP_W = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 1;

  logic [COL_W-1:0]   col_q, col_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               s1_valid_q, s1_valid_d;
  logic [PIXEL_W-1:0] s1_pixel_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [ROW_W-1:0]   s1_row_q;
  logic [CCMP_W-1:0]  col_inc;
  logic [RCMP_W-1:0]  row_inc;
  logic               accept;

  assign in_ready_o = !s1_valid_q || s1_take_i;
  assign accept     = in_valid_i && in_ready_o;

  // a counter at or past the size wraps as at the end of a line
  always_comb begin
    col_inc = CCMP_W'(col_q) + CCMP_W'(1);
    row_inc = RCMP_W'(row_q) + RCMP_W'(1);
    col_d   = col_q;
    row_d   = row_q;
    if (accept) begin
      if (col_inc >= CCMP_W'(cfg_i.src_width)) begin
        col_d = '0;
        if (row_inc >= RCMP_W'(cfg_i.src_height)) row_d = '0;
        else                                      row_d = row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[COL_W-1:0];
      end
    end
  end

  always_comb begin
    if (accept)         s1_valid_d = 1'b1;
    else if (s1_take_i) s1_valid_d = 1'b0;
    else                s1_valid_d = s1_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q <= in_pixel_i;
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_pixel_o = s1_pixel_q;
  assign s1_col_o   = s1_col_q;
  assign s1_row_o   = s1_row_q;

endmodule

// ===== rtl/ccb_writer.sv =====
`timescale 1ns / 1ps

module ccb_writer #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096,
  localparam int unsigned COL_W = $clog2(MAX_WIDTH),
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ccb_pkg::cfg_t                cfg_i,
  input  logic                         s1_valid_i,
  output logic                         s1_take_o,
  input  logic [ccb_pkg::PIXEL_W-1:0]  s1_pixel_i,
  input  logic [COL_W-1:0]             s1_col_i,
  input  logic [ROW_W-1:0]             s1_row_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output ccb_pkg::wr_word_t            out_word_o
);
  import ccb_pkg::*;

  localparam int unsigned DX_W = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 2;
  localparam int unsigned DY_W = ((ROW_W > SIZE_W) ? ROW_W : SIZE_W) + 2;

  logic signed [DX_W-1:0] dx;
  logic signed [DY_W-1:0] dy;
  logic                   in_image, keyed, hit, out_free, load;
  logic [2*SIZE_W-1:0]    row_base;
  logic [ADDR_W-1:0]      addr;
  logic                   out_valid_q, out_valid_d;
  wr_word_t               out_word_q;

  always_comb begin
    dx = DX_W'(cfg_i.dest_x) + $signed({{(DX_W-COL_W){1'b0}}, s1_col_i});
    dy = DY_W'(cfg_i.dest_y) + $signed({{(DY_W-ROW_W){1'b0}}, s1_row_i});
    in_image = !dx[DX_W-1] && !dy[DY_W-1]
            && (dx[DX_W-2:0] < (DX_W-1)'(cfg_i.image_width))
            && (dy[DY_W-2:0] < (DY_W-1)'(cfg_i.image_height));
    keyed  = cfg_i.key_enable && (s1_pixel_i == cfg_i.key_color);
    hit    = in_image && !keyed;
    // inside the image both coordinates fit the 13-bit size range
    row_base = dy[SIZE_W-1:0] * cfg_i.image_width;
    addr     = ADDR_W'(row_base + (2*SIZE_W)'(dx[SIZE_W-1:0]));
  end

  assign out_free  = !out_valid_q || out_ready_i;
  // dropped pixels leave at once, hits wait for a free output slot
  assign s1_take_o = !hit || out_free;
  assign load      = s1_valid_i && hit && out_free;

  always_comb begin
    if (load)             out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else                  out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else         out_valid_q <= out_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_word_q.pixel_address <= addr;
      out_word_q.pixel_color   <= s1_pixel_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/clipped_color_key_blitter_unit.sv =====
`timescale 1ns / 1ps

// channel   dir   word        fields
// src_i     in    src_word_t  src_pixel
// wr_o      out   wr_word_t   pixel_address, pixel_color
// cfg_*     in    write port  cfg_idx_i selects the register, cfg_data_i carries it
//
// one pixel accepted per cycle unless wr_o stalls; a write word passes
// through an input register and then an output register on its way to wr_o.
// a clipped or keyed pixel still advances the column and row counters.
// reset clears the counters and both valid flags and loads the register defaults.
// a stall on wr_o backs up through the input register to src_i.ready.
module clipped_color_key_blitter_unit #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  ccb_stream_if.sink                src_i,
  ccb_stream_if.source              wr_o,
  input  logic                      cfg_we_i,
  input  logic [ccb_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [ccb_pkg::CFG_W-1:0] cfg_data_i
);
  import ccb_pkg::*;

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

  cfg_t               cfg;
  logic               s1_valid, s1_take;
  logic [PIXEL_W-1:0] s1_pixel;
  logic [COL_W-1:0]   s1_col;
  logic [ROW_W-1:0]   s1_row;
  wr_word_t           out_word;
  src_word_t          in_word;

  assign in_word = src_i.payload;

  ccb_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .cfg_o     (cfg)
  );

  ccb_walker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_walker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_valid_i(src_i.valid),
    .in_ready_o(src_i.ready),
    .in_pixel_i(in_word.src_pixel),
    .s1_valid_o(s1_valid),
    .s1_take_i (s1_take),
    .s1_pixel_o(s1_pixel),
    .s1_col_o  (s1_col),
    .s1_row_o  (s1_row)
  );

  ccb_writer #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_writer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s1_valid_i (s1_valid),
    .s1_take_o  (s1_take),
    .s1_pixel_i (s1_pixel),
    .s1_col_i   (s1_col),
    .s1_row_i   (s1_row),
    .out_valid_o(wr_o.valid),
    .out_ready_i(wr_o.ready),
    .out_word_o (out_word)
  );

  assign wr_o.payload = out_word;

endmodule
